@@ rtl/slle_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slle_pkg: shared definitions of the static linked list engine
// Command and status codes, fixed port widths and the result record that the
// sequencer hands to the output register.
// ----------------------------------------------------------------------------
package slle_pkg;

    // Fixed widths of the channel fields
    localparam int CMD_W     = 2;
    localparam int POS_W     = 6;
    localparam int VALUE_W   = 32;
    localparam int STATUS_W  = 2;
    localparam int COUNT_W   = 6;

    // Widest data word the storage may be built with
    localparam int MAX_DATA_W = 64;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ   = 2'd2;
    localparam logic [CMD_W-1:0] CMD_LENGTH = 2'd3;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BADPOS = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL   = 2'd2;

    // One result transfer
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [VALUE_W-1:0]  read_value;
        logic [POS_W-1:0]    taken_node;
        logic [COUNT_W-1:0]  list_length;
    } slle_res_t;

endpackage

@@ rtl/slle_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slle_ram: single-port synchronous memory
// One write or one read per cycle; read data is registered.
// ----------------------------------------------------------------------------
module slle_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write, or read into the output register
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end else begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/slle_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slle_ctrl: command sequencer of the static linked list engine
// Clears the link memory after reset, checks each command, walks the link
// chain one node a cycle and splices nodes in and out of the list.
// ----------------------------------------------------------------------------
module slle_ctrl #(
    parameter int NODES      = 64,
    parameter int DATA_WIDTH = 32
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // command channel
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [slle_pkg::CMD_W-1:0]        s_cmd,
    input  logic [slle_pkg::POS_W-1:0]        s_position,
    input  logic [slle_pkg::VALUE_W-1:0]      s_value,
    // result hand-off
    output logic                              res_valid,
    input  logic                              res_ready,
    output slle_pkg::slle_res_t               res,
    // link memory port
    output logic                              link_we,
    output logic [$clog2(NODES)-1:0]          link_addr,
    output logic [$clog2(NODES)-1:0]          link_wdata,
    input  logic [$clog2(NODES)-1:0]          link_rdata,
    // data memory port
    output logic                              data_we,
    output logic [$clog2(NODES)-1:0]          data_addr,
    output logic [DATA_WIDTH-1:0]             data_wdata,
    input  logic [DATA_WIDTH-1:0]             data_rdata
);

    localparam int IW = $clog2(NODES);
    localparam int CW = ((IW > slle_pkg::POS_W) ? IW : slle_pkg::POS_W) + 1;
    localparam logic [IW-1:0] LIST_HEAD  = IW'(NODES - 1);
    localparam logic [IW:0]   NODES_EXT  = (IW + 1)'(NODES);
    localparam logic [IW:0]   CLR_LINKED = (IW + 1)'(NODES - 2);

    // Sequencer states
    localparam logic [3:0] S_CLEAR    = 4'd0;
    localparam logic [3:0] S_IDLE     = 4'd1;
    localparam logic [3:0] S_WALK0    = 4'd2;
    localparam logic [3:0] S_WALK     = 4'd3;
    localparam logic [3:0] S_INS_LINK = 4'd4;
    localparam logic [3:0] S_INS_PRE  = 4'd5;
    localparam logic [3:0] S_RD_DATA  = 4'd6;
    localparam logic [3:0] S_DEL_PRE  = 4'd7;
    localparam logic [3:0] S_DEL_FREE = 4'd8;
    localparam logic [3:0] S_DONE     = 4'd9;

    logic [3:0]                          state_reg, state_next;
    logic [IW-1:0]                       clr_reg, clr_next;
    logic [IW-1:0]                       count_reg, count_next;
    logic [IW-1:0]                       free_head_reg, free_head_next;
    logic [slle_pkg::CMD_W-1:0]          cmd_reg, cmd_next;
    logic [DATA_WIDTH-1:0]               value_reg, value_next;
    logic [slle_pkg::POS_W-1:0]          steps_reg, steps_next;
    logic [IW-1:0]                       cur_reg, cur_next;
    logic [IW-1:0]                       pre_reg, pre_next;
    logic [IW-1:0]                       succ_reg, succ_next;
    logic [IW-1:0]                       nfree_reg, nfree_next;
    logic [slle_pkg::STATUS_W-1:0]       status_reg, status_next;
    logic [slle_pkg::VALUE_W-1:0]        rdval_reg, rdval_next;
    logic [slle_pkg::POS_W-1:0]          node_reg, node_next;

    logic [IW-1:0]                       link_clean;
    logic [CW-1:0]                       pos_ext;
    logic [CW-1:0]                       cnt_ext;
    logic                                pos_nz;
    logic                                ins_ok;
    logic                                acc_ok;
    logic                                full;
    logic [slle_pkg::MAX_DATA_W-1:0]     value_wide;
    logic [slle_pkg::MAX_DATA_W-1:0]     rd_wide;

    // Treat an out-of-range link as the end of the chain
    assign link_clean = ({1'b0, link_rdata} < NODES_EXT) ? link_rdata : '0;

    // Position and free chain checks
    assign pos_ext = CW'(s_position);
    assign cnt_ext = CW'(count_reg);
    assign pos_nz  = (s_position != '0);
    assign ins_ok  = pos_nz && (pos_ext <= cnt_ext + CW'(1));
    assign acc_ok  = pos_nz && (pos_ext <= cnt_ext);
    assign full    = (free_head_reg == '0) || (free_head_reg == LIST_HEAD);

    // Fit data words between port and storage widths
    always_comb begin
        value_wide = '0;
        value_wide[slle_pkg::VALUE_W-1:0] = s_value;
        rd_wide = '0;
        rd_wide[DATA_WIDTH-1:0] = data_rdata;
    end

    // Sequencer
    always_comb begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        count_next     = count_reg;
        free_head_next = free_head_reg;
        cmd_next       = cmd_reg;
        value_next     = value_reg;
        steps_next     = steps_reg;
        cur_next       = cur_reg;
        pre_next       = pre_reg;
        succ_next      = succ_reg;
        nfree_next     = nfree_reg;
        status_next    = status_reg;
        rdval_next     = rdval_reg;
        node_next      = node_reg;
        link_we        = 1'b0;
        link_addr      = free_head_reg;
        link_wdata     = '0;
        data_we        = 1'b0;
        data_addr      = link_clean;
        data_wdata     = value_reg;
        s_ready        = 1'b0;

        unique case (state_reg)
            S_CLEAR: begin
                // rebuild the free chain one node a cycle
                link_we    = 1'b1;
                link_addr  = clr_reg;
                link_wdata = ({1'b0, clr_reg} < CLR_LINKED) ? clr_reg + IW'(1) : '0;
                clr_next   = clr_reg + IW'(1);
                if (clr_reg == LIST_HEAD) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                // fetch the link of the free head ahead of an insert
                s_ready   = 1'b1;
                link_addr = free_head_reg;
                if (s_valid) begin
                    cmd_next    = s_cmd;
                    value_next  = value_wide[DATA_WIDTH-1:0];
                    steps_next  = s_position - slle_pkg::POS_W'(1);
                    rdval_next  = '0;
                    node_next   = '0;
                    status_next = slle_pkg::ST_OK;
                    state_next  = S_WALK0;
                    priority if (s_cmd == slle_pkg::CMD_LENGTH) begin
                        state_next = S_DONE;
                    end else if (s_cmd == slle_pkg::CMD_INSERT) begin
                        priority if (!ins_ok) begin
                            status_next = slle_pkg::ST_BADPOS;
                            state_next  = S_DONE;
                        end else if (full) begin
                            status_next = slle_pkg::ST_FULL;
                            state_next  = S_DONE;
                        end else begin
                            state_next = S_WALK0;
                        end
                    end else if (!acc_ok) begin
                        status_next = slle_pkg::ST_BADPOS;
                        state_next  = S_DONE;
                    end else begin
                        state_next = S_WALK0;
                    end
                end
            end
            S_WALK0: begin
                // keep the next free node, start at the list head
                nfree_next = link_clean;
                link_addr  = LIST_HEAD;
                cur_next   = LIST_HEAD;
                state_next = S_WALK;
            end
            S_WALK: begin
                // follow one link a cycle until the predecessor is reached
                link_addr = link_clean;
                if (steps_reg != '0) begin
                    cur_next   = link_clean;
                    steps_next = steps_reg - slle_pkg::POS_W'(1);
                end else begin
                    pre_next  = cur_reg;
                    succ_next = link_clean;
                    unique case (cmd_reg)
                        slle_pkg::CMD_INSERT: state_next = S_INS_LINK;
                        slle_pkg::CMD_READ:   state_next = S_RD_DATA;
                        slle_pkg::CMD_DELETE: begin
                            if (link_clean == '0 || link_clean == LIST_HEAD) begin
                                state_next = S_DONE;
                            end else begin
                                state_next = S_DEL_PRE;
                            end
                        end
                        default: state_next = S_DONE;
                    endcase
                end
            end
            S_INS_LINK: begin
                // point the fresh node at the successor and store its data
                link_we    = 1'b1;
                link_addr  = free_head_reg;
                link_wdata = succ_reg;
                data_we    = 1'b1;
                data_addr  = free_head_reg;
                state_next = S_INS_PRE;
            end
            S_INS_PRE: begin
                // splice the fresh node in and advance the free chain
                link_we        = 1'b1;
                link_addr      = pre_reg;
                link_wdata     = free_head_reg;
                node_next      = slle_pkg::POS_W'(free_head_reg);
                free_head_next = nfree_reg;
                count_next     = count_reg + IW'(1);
                state_next     = S_DONE;
            end
            S_RD_DATA: begin
                rdval_next = rd_wide[slle_pkg::VALUE_W-1:0];
                state_next = S_DONE;
            end
            S_DEL_PRE: begin
                // unlink the victim: its link is in the read register
                link_we    = 1'b1;
                link_addr  = pre_reg;
                link_wdata = link_clean;
                state_next = S_DEL_FREE;
            end
            S_DEL_FREE: begin
                // push the victim on the front of the free chain
                link_we        = 1'b1;
                link_addr      = succ_reg;
                link_wdata     = free_head_reg;
                free_head_next = succ_reg;
                count_next     = count_reg - IW'(1);
                state_next     = S_DONE;
            end
            S_DONE: begin
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            count_reg     <= '0;
            free_head_reg <= IW'(1);
        end else begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            count_reg     <= count_next;
            free_head_reg <= free_head_next;
        end
    end

    // Working registers
    always_ff @(posedge aclk) begin
        cmd_reg    <= cmd_next;
        value_reg  <= value_next;
        steps_reg  <= steps_next;
        cur_reg    <= cur_next;
        pre_reg    <= pre_next;
        succ_reg   <= succ_next;
        nfree_reg  <= nfree_next;
        status_reg <= status_next;
        rdval_reg  <= rdval_next;
        node_reg   <= node_next;
    end

    // Result record
    assign res_valid       = (state_reg == S_DONE);
    assign res.status      = status_reg;
    assign res.read_value  = rdval_reg;
    assign res.taken_node  = node_reg;
    assign res.list_length = slle_pkg::COUNT_W'(count_reg);

endmodule

@@ rtl/static_linked_list_engine.sv @@
`timescale 1ns / 1ps
// Sequence: query and rejected commands go straight to S_DONE, then to m_valid;
// read, insert and delete first walk the link chain, then read or splice.
// Throughput: one command at a time; the link walk reads one node per cycle
// from the single-port link memory.
// Reset: synchronous, active low; a clearing pass rebuilds the free chain,
// with s_ready low until it ends.
// ----------------------------------------------------------------------------
// static_linked_list_engine: array-backed linked list with a free list
// Insert, delete, read and length commands over a memory of link words and a
// memory of data words; one result per command through an output register.
// ----------------------------------------------------------------------------
module static_linked_list_engine #(
    parameter int NODES      = 64,
    parameter int DATA_WIDTH = 32
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [slle_pkg::CMD_W-1:0]        s_cmd,
    input  logic [slle_pkg::POS_W-1:0]        s_position,
    input  logic [slle_pkg::VALUE_W-1:0]      s_value,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [slle_pkg::STATUS_W-1:0]     m_status,
    output logic [slle_pkg::VALUE_W-1:0]      m_read_value,
    output logic [slle_pkg::POS_W-1:0]        m_taken_node,
    output logic [slle_pkg::COUNT_W-1:0]      m_list_length
);

    localparam int IW = $clog2(NODES);

    logic                  link_we;
    logic [IW-1:0]         link_addr;
    logic [IW-1:0]         link_wdata;
    logic [IW-1:0]         link_rdata;
    logic                  data_we;
    logic [IW-1:0]         data_addr;
    logic [DATA_WIDTH-1:0] data_wdata;
    logic [DATA_WIDTH-1:0] data_rdata;

    logic                  res_valid;
    logic                  res_ready;
    slle_pkg::slle_res_t   res;

    logic                  m_valid_reg;
    slle_pkg::slle_res_t   m_res_reg;

    // Link words
    slle_ram #(
        .DEPTH (NODES),
        .WIDTH (IW)
    ) u_link_ram (
        .aclk  (aclk),
        .we    (link_we),
        .addr  (link_addr),
        .wdata (link_wdata),
        .rdata (link_rdata)
    );

    // Data words
    slle_ram #(
        .DEPTH (NODES),
        .WIDTH (DATA_WIDTH)
    ) u_data_ram (
        .aclk  (aclk),
        .we    (data_we),
        .addr  (data_addr),
        .wdata (data_wdata),
        .rdata (data_rdata)
    );

    // Command sequencer
    slle_ctrl #(
        .NODES      (NODES),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_cmd      (s_cmd),
        .s_position (s_position),
        .s_value    (s_value),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res),
        .link_we    (link_we),
        .link_addr  (link_addr),
        .link_wdata (link_wdata),
        .link_rdata (link_rdata),
        .data_we    (data_we),
        .data_addr  (data_addr),
        .data_wdata (data_wdata),
        .data_rdata (data_rdata)
    );

    // Take a result when the output register is empty or draining
    assign res_ready = !m_valid_reg || m_ready;

    // Output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_ready) begin
            m_valid_reg <= res_valid;
        end
    end

    // Output payload: load on each new result
    always_ff @(posedge aclk) begin
        if (res_ready && res_valid) begin
            m_res_reg <= res;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = m_res_reg.status;
    assign m_read_value  = m_res_reg.read_value;
    assign m_taken_node  = m_res_reg.taken_node;
    assign m_list_length = m_res_reg.list_length;

endmodule
